>>> rtl/core/sbck_pkg.sv
// shared types and constants of the color keyed sprite blitter
package sbck_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 200;

    localparam int SIZE_W   = 9;
    localparam int BASE_W   = 10;
    localparam int COORD_W  = BASE_W + 1;
    localparam int COLOR_W  = 8;
    localparam int ADDR_W   = 16;
    localparam int MUL_W    = COORD_W + $clog2(SCREEN_WIDTH + 1) + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SIZE_W;

    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 1'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // classified pixel handed from front to back
    typedef struct packed {
        logic               wr;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [COLOR_W-1:0] color;
        logic               done;
    } task_t;

    // handshake between queue and its neighbors
    typedef struct packed {
        logic  valid;
        task_t entry;
    } push_t;

endpackage

>>> rtl/core/sbck_pixel_if.sv
// pixel input channel
interface sbck_pixel_if;
    import sbck_pkg::*;
    logic               valid;
    logic               ready;
    logic               start_of_sprite;
    logic [BASE_W-1:0]  origin_x;
    logic [BASE_W-1:0]  origin_y;
    logic [COLOR_W-1:0] pixel;

    modport source (output valid, start_of_sprite, origin_x, origin_y, pixel, input ready);
    modport sink (input valid, start_of_sprite, origin_x, origin_y, pixel, output ready);
endinterface

>>> rtl/core/sbck_write_if.sv
// frame-buffer write output channel
interface sbck_write_if;
    import sbck_pkg::*;
    logic               valid;
    logic               ready;
    logic               write_enable;
    logic [ADDR_W-1:0]  address;
    logic [COLOR_W-1:0] color;
    logic               sprite_done;

    modport source (output valid, write_enable, address, color, sprite_done, input ready);
    modport sink (input valid, write_enable, address, color, sprite_done, output ready);
endinterface

>>> rtl/core/sbck_cfg_if.sv
// configuration write channel
interface sbck_cfg_if;
    import sbck_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/sbck_front.sv
// front end: size registers, sprite counters and pixel classification
module sbck_front (
    input  logic              clk,
    input  logic              rst_n,
    sbck_pixel_if.sink        pixels,
    sbck_cfg_if.sink          cfg,
    input  logic              push_ready,
    output sbck_pkg::push_t   push
);
    import sbck_pkg::*;

    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [SIZE_W-1:0] col_cnt_reg, col_cnt_next;
    logic [SIZE_W-1:0] row_cnt_reg, row_cnt_next;
    logic [BASE_W-1:0] base_col_reg, base_col_next;
    logic [BASE_W-1:0] base_row_reg, base_row_next;
    logic              active_reg, active_next;

    logic               accept;
    logic               cur_active;
    logic [SIZE_W-1:0]  cur_col_cnt, cur_row_cnt;
    logic [SIZE_W-1:0]  width_eff, height_eff;
    logic [COORD_W-1:0] scr_col, scr_row;
    logic               last_col, last_row;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_W'(1);
            height_reg <= SIZE_W'(1);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SPRITE_WIDTH:  width_reg  <= cfg.data;
                REG_SPRITE_HEIGHT: height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign accept = pixels.valid && push_ready;
    assign pixels.ready = push_ready;

    // a start pixel restarts the counters before it is classified
    assign cur_active  = pixels.start_of_sprite || active_reg;
    assign cur_col_cnt = pixels.start_of_sprite ? '0 : col_cnt_reg;
    assign cur_row_cnt = pixels.start_of_sprite ? '0 : row_cnt_reg;

    always_comb
    begin
        base_col_next = base_col_reg;
        base_row_next = base_row_reg;
        if (pixels.start_of_sprite)
        begin
            base_col_next = pixels.origin_x;
            base_row_next = pixels.origin_y;
        end
    end

    assign width_eff  = (width_reg == '0) ? SIZE_W'(1) : width_reg;
    assign height_eff = (height_reg == '0) ? SIZE_W'(1) : height_reg;

    assign scr_col = {1'b0, base_col_next} + COORD_W'(cur_col_cnt);
    assign scr_row = {1'b0, base_row_next} + COORD_W'(cur_row_cnt);

    assign last_col = ({1'b0, cur_col_cnt} + (SIZE_W+1)'(1)) >= {1'b0, width_eff};
    assign last_row = ({1'b0, cur_row_cnt} + (SIZE_W+1)'(1)) >= {1'b0, height_eff};

    always_comb
    begin
        active_next  = cur_active;
        col_cnt_next = cur_col_cnt;
        row_cnt_next = cur_row_cnt;
        if (cur_active)
        begin
            if (last_col && last_row)
            begin
                active_next  = 1'b0;
                col_cnt_next = '0;
                row_cnt_next = '0;
            end
            else if (last_col)
            begin
                col_cnt_next = '0;
                row_cnt_next = cur_row_cnt + SIZE_W'(1);
            end
            else
            begin
                col_cnt_next = cur_col_cnt + SIZE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            base_col_reg <= '0;
            base_row_reg <= '0;
        end
        else if (accept)
        begin
            active_reg   <= active_next;
            col_cnt_reg  <= col_cnt_next;
            row_cnt_reg  <= row_cnt_next;
            base_col_reg <= base_col_next;
            base_row_reg <= base_row_next;
        end
    end

    assign push.valid       = pixels.valid;
    assign push.entry.wr    = cur_active && (pixels.pixel != '0)
                              && (scr_col < COORD_W'(SCREEN_WIDTH))
                              && (scr_row < COORD_W'(SCREEN_HEIGHT));
    assign push.entry.row   = scr_row;
    assign push.entry.col   = scr_col;
    assign push.entry.color = pixels.pixel;
    assign push.entry.done  = cur_active && last_col && last_row;

endmodule

>>> rtl/core/sbck_queue.sv
// short queue of classified pixels between front and back
module sbck_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  sbck_pkg::push_t   push,
    output logic              push_ready,
    output sbck_pkg::push_t   pop,
    input  logic              pop_ready
);
    import sbck_pkg::*;

    task_t             slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            return '0;
        else
            return p + QPTR_W'(1);
    endfunction

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop.valid && pop_ready;

    assign pop.valid = (count_reg != '0);
    assign pop.entry = slots[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push.entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/core/sbck_back.sv
// back end: address multiply and registered write output
module sbck_back (
    input  logic              clk,
    input  logic              rst_n,
    input  sbck_pkg::push_t   pop,
    output logic              pop_ready,
    sbck_write_if.source      writes
);
    import sbck_pkg::*;

    logic               valid_reg;
    logic               we_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               done_reg;
    logic [MUL_W-1:0]   addr_full;
    logic               load;

    // row times screen width plus column, kept to the low address bits
    assign addr_full = MUL_W'(pop.entry.row) * MUL_W'(SCREEN_WIDTH) + MUL_W'(pop.entry.col);

    assign pop_ready = !valid_reg || writes.ready;
    assign load      = pop.valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop_ready)
            valid_reg <= pop.valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            we_reg    <= pop.entry.wr;
            addr_reg  <= pop.entry.wr ? addr_full[ADDR_W-1:0] : '0;
            color_reg <= pop.entry.wr ? pop.entry.color : '0;
            done_reg  <= pop.entry.done;
        end
    end

    assign writes.valid        = valid_reg;
    assign writes.write_enable = we_reg;
    assign writes.address      = addr_reg;
    assign writes.color        = color_reg;
    assign writes.sprite_done  = done_reg;

endmodule

>>> rtl/core/sprite_blit_color_key_clip.sv
// top level of the color keyed sprite blitter with right and bottom clipping
//
//   channel  dir  handshake        carries
//   pixels   in   valid / ready    start_of_sprite, origin_x, origin_y, pixel
//   writes   out  valid / ready    write_enable, address, color, sprite_done
//   cfg      in   valid / ready    index (0 width, 1 height), data
//
// one pixel per clock sustained while writes.ready stays high; every pixel yields exactly one write item
// an accepted pixel's write item passes through a queue slot, then the output register
// a stalled writes channel fills the two-entry queue, then pixels.ready drops
// reset clears counters and control, sizes return to 1; cfg.ready is always high
module sprite_blit_color_key_clip (
    input  logic          clk,
    input  logic          rst_n,
    sbck_pixel_if.sink    pixels,
    sbck_write_if.source  writes,
    sbck_cfg_if.sink      cfg
);
    import sbck_pkg::*;

    push_t push;
    push_t pop;
    logic  push_ready;
    logic  pop_ready;

    sbck_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixels     (pixels),
        .cfg        (cfg),
        .push_ready (push_ready),
        .push       (push)
    );

    sbck_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_ready  (pop_ready)
    );

    sbck_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .pop_ready (pop_ready),
        .writes    (writes)
    );

endmodule

>>> rtl/core/sbck_checker.sv
// port-level checks of the sprite blitter and their bind
module sbck_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       write_enable,
    input  logic [sbck_pkg::ADDR_W-1:0]  address,
    input  logic [sbck_pkg::COLOR_W-1:0] color,
    input  logic                       sprite_done
);
    import sbck_pkg::*;

    localparam int MAX_OUT = QUEUE_DEPTH + 1;
    localparam int OCNT_W  = $clog2(MAX_OUT + 2);

    logic [OCNT_W-1:0] outstanding_reg;
    logic              in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // items accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outstanding_reg <= '0;
        else if (in_acc && !out_acc)
            outstanding_reg <= outstanding_reg + OCNT_W'(1);
        else if (out_acc && !in_acc)
            outstanding_reg <= outstanding_reg - OCNT_W'(1);
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(write_enable)
            && $stable(address) && $stable(color) && $stable(sprite_done))
        else $error("write item changed while stalled");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_enable |-> address == '0 && color == '0)
        else $error("suppressed write carries address or color");

    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_enable
            && (SCREEN_WIDTH * SCREEN_HEIGHT <= (1 << ADDR_W))
        |-> (32'(address) < 32'(SCREEN_WIDTH * SCREEN_HEIGHT)) && color != '0)
        else $error("write outside frame buffer or transparent");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> outstanding_reg != '0)
        else $error("write item without an accepted pixel");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= OCNT_W'(MAX_OUT))
        else $error("more items in flight than storage holds");

endmodule

bind sprite_blit_color_key_clip sbck_checker u_sbck_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (pixels.valid),
    .in_ready     (pixels.ready),
    .out_valid    (writes.valid),
    .out_ready    (writes.ready),
    .write_enable (writes.write_enable),
    .address      (writes.address),
    .color        (writes.color),
    .sprite_done  (writes.sprite_done)
);

>>> dv/sprite_blit_color_key_clip_test.sv
`timescale 1ns / 1ps
// self-checking testbench of the color keyed sprite blitter: predicted frame-buffer writes vs dut
module sprite_blit_color_key_clip_test;
    import sbck_pkg::*;

    typedef struct packed {
        logic               write_enable;
        logic [ADDR_W-1:0]  address;
        logic [COLOR_W-1:0] color;
        logic               sprite_done;
    } fb_write_t;

    logic clk = 1'b0;
    logic rst_n;

    sbck_pixel_if pix_if();
    sbck_write_if wr_if();
    sbck_cfg_if   cfg_if();

    sprite_blit_color_key_clip u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixels (pix_if),
        .writes (wr_if),
        .cfg    (cfg_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // blitter state as predicted
    logic [SIZE_W-1:0] blit_width;
    logic [SIZE_W-1:0] blit_height;
    logic [SIZE_W-1:0] blit_col;
    logic [SIZE_W-1:0] blit_row;
    logic [BASE_W-1:0] blit_base_col;
    logic [BASE_W-1:0] blit_base_row;
    logic              blit_active;

    fb_write_t pending_writes[$];

    bit src_idle;
    bit snk_idle;
    int n_pixels;
    int n_fb_writes;
    int n_no_writes;
    int n_done;
    int n_settings;
    int n_mismatch;

    function automatic int size_eff(input int v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic fb_write_t predict_write(input logic start,
                                                input logic [BASE_W-1:0] ox,
                                                input logic [BASE_W-1:0] oy,
                                                input logic [COLOR_W-1:0] px);
        fb_write_t res;
        int scr_col;
        int scr_row;
        logic last_col;
        logic last_row;
        res = '0;
        if (start)
        begin
            blit_base_col = ox;
            blit_base_row = oy;
            blit_col = '0;
            blit_row = '0;
            blit_active = 1'b1;
        end
        if (!blit_active)
            return res;
        scr_col = int'(blit_base_col) + int'(blit_col);
        scr_row = int'(blit_base_row) + int'(blit_row);
        if (px != 0 && scr_col < SCREEN_WIDTH && scr_row < SCREEN_HEIGHT)
        begin
            res.write_enable = 1'b1;
            res.address = ADDR_W'(scr_row * SCREEN_WIDTH + scr_col);
            res.color = px;
        end
        // sizes may shrink under a running sprite, hence >= rather than ==
        last_col = (int'(blit_col) + 1 >= size_eff(int'(blit_width)));
        last_row = (int'(blit_row) + 1 >= size_eff(int'(blit_height)));
        if (last_col && last_row)
        begin
            res.sprite_done = 1'b1;
            blit_active = 1'b0;
            blit_col = '0;
            blit_row = '0;
        end
        else if (last_col)
        begin
            blit_col = '0;
            blit_row = blit_row + 1'b1;
        end
        else
            blit_col = blit_col + 1'b1;
        return res;
    endfunction

    task automatic send_pixel(input logic start, input logic [BASE_W-1:0] ox,
                              input logic [BASE_W-1:0] oy, input logic [COLOR_W-1:0] px);
        int gap;
        gap = src_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.start_of_sprite <= start;
        pix_if.origin_x <= ox;
        pix_if.origin_y <= oy;
        pix_if.pixel <= px;
        @(posedge clk);
        while (!pix_if.ready) @(posedge clk);
        pending_writes.push_back(predict_write(start, ox, oy, px));
        n_pixels++;
    endtask

    // stray item: start low, origin fields are don't-care
    task automatic send_stray(input logic [COLOR_W-1:0] px);
        send_pixel(1'b0, BASE_W'($urandom), BASE_W'($urandom), px);
    endtask

    task automatic wait_drained();
        pix_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_writes.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        if (idx == REG_SPRITE_WIDTH)
            blit_width = SIZE_W'(value);
        else
            blit_height = SIZE_W'(value);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_sizes(input int wv, input int hv);
        wait_drained();
        write_reg(REG_SPRITE_WIDTH, wv);
        write_reg(REG_SPRITE_HEIGHT, hv);
        n_settings++;
    endtask

    function automatic logic [BASE_W-1:0] pick_coord(input int screen_edge);
        case ($urandom_range(0, 3))
            0: return BASE_W'($urandom_range(0, 1023));
            1: return BASE_W'($urandom_range(screen_edge - 8, screen_edge + 8));
            2: return BASE_W'($urandom_range(0, 7));
            default: return BASE_W'($urandom_range(0, screen_edge - 1));
        endcase
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        return ($urandom_range(0, 3) == 0) ? '0 : COLOR_W'($urandom_range(0, 255));
    endfunction

    // first item carries start and origin, the rest are plain pixels
    task automatic blit_sprite(input int count);
        logic [BASE_W-1:0] ox;
        logic [BASE_W-1:0] oy;
        ox = pick_coord(SCREEN_WIDTH);
        oy = pick_coord(SCREEN_HEIGHT);
        send_pixel(1'b1, ox, oy, pick_color());
        for (int i = 1; i < count; i++)
            send_stray(pick_color());
    endtask

    task automatic run_phase(input int wv, input int hv, input int budget);
        int len;
        int cut;
        int sent;
        set_sizes(wv, hv);
        src_idle = ($urandom_range(0, 3) != 0);
        snk_idle = ($urandom_range(0, 3) != 0);
        len = size_eff(wv) * size_eff(hv);
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                cut = $urandom_range(1, 3);
                repeat (cut) send_stray(COLOR_W'($urandom_range(0, 255)));
                sent += cut;
            end
            cut = len;
            // broken sprite: the next start abandons it
            if (len > budget || $urandom_range(0, 9) == 0)
                cut = $urandom_range(1, (len < budget) ? len : budget);
            blit_sprite(cut);
            sent += cut;
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end
    endtask

    task automatic test_reset_sizes();
        src_idle = 1'b1;
        snk_idle = 1'b1;
        send_stray(8'hFF);
        send_pixel(1'b1, 10'd0, 10'd0, 8'hFF);
        send_stray(8'h5A);
        send_pixel(1'b1, 10'h3FF, 10'h3FF, 8'h01);
        send_pixel(1'b1, 10'd319, 10'd199, 8'h80);
        send_pixel(1'b1, 10'd319, 10'd199, 8'h00);
    endtask

    // 2x2 sprite straddling the bottom right corner
    task automatic test_clipping();
        set_sizes(2, 2);
        send_pixel(1'b1, 10'd319, 10'd199, 8'h11);
        send_stray(8'h22);
        send_stray(8'h33);
        send_stray(8'h44);
    endtask

    task automatic test_restart();
        send_pixel(1'b1, 10'd5, 10'd5, 8'hA5);
        send_pixel(1'b1, 10'd6, 10'd6, 8'h5A);
        send_stray(8'h01);
        send_stray(8'h00);
        send_stray(8'hFE);
        send_stray(8'h77);
    endtask

    task automatic test_zero_size();
        set_sizes(0, 0);
        send_pixel(1'b1, 10'd100, 10'd50, 8'h42);
        send_stray(8'h42);
    endtask

    task automatic test_resize_mid_sprite();
        set_sizes(8, 2);
        send_pixel(1'b1, 10'd0, 10'd0, 8'h10);
        send_stray(8'h20);
        send_stray(8'h30);
        wait_drained();
        // column count already past the new width
        write_reg(REG_SPRITE_WIDTH, 2);
        send_stray(8'h40);
        send_stray(8'h50);
        send_stray(8'h60);
    endtask

    task automatic test_random_sprites();
        int wv;
        int hv;
        run_phase(511, 1, 511);
        run_phase(1, 511, 80);
        run_phase(0, 0, 40);
        while (n_pixels < 1700)
        begin
            case ($urandom_range(0, 7))
                0:
                begin
                    wv = $urandom_range(0, 511);
                    hv = $urandom_range(0, 2);
                end
                1:
                begin
                    wv = $urandom_range(0, 2);
                    hv = $urandom_range(0, 511);
                end
                default:
                begin
                    wv = $urandom_range(0, 12);
                    hv = $urandom_range(0, 6);
                end
            endcase
            run_phase(wv, hv, 120);
        end
    endtask

    // write side: per item stall, then compare with oldest prediction
    initial
    begin : write_sink
        int stall;
        fb_write_t got;
        fb_write_t want;
        wr_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = snk_idle ? $urandom_range(0, 16) : 0;
            if (stall > 0)
            begin
                wr_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            wr_if.ready <= 1'b1;
            @(posedge clk);
            while (!wr_if.valid) @(posedge clk);
            got.write_enable = wr_if.write_enable;
            got.address = wr_if.address;
            got.color = wr_if.color;
            got.sprite_done = wr_if.sprite_done;
            if (pending_writes.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected write item: we=%0b addr=%0d color=%0d done=%0b",
                             got.write_enable, got.address, got.color, got.sprite_done);
            end
            else
            begin
                want = pending_writes.pop_front();
                if (got !== want)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"write item mismatch: expected we=%0b addr=%0d color=%0d ",
                                  "done=%0b, got we=%0b addr=%0d color=%0d done=%0b"},
                                 want.write_enable, want.address, want.color,
                                 want.sprite_done, got.write_enable, got.address,
                                 got.color, got.sprite_done);
                end
                if (want.write_enable)
                    n_fb_writes++;
                else
                    n_no_writes++;
                if (want.sprite_done)
                    n_done++;
            end
        end
    end

    initial
    begin
        #20000000;
        $display("timeout with %0d write items outstanding", pending_writes.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        pix_if.valid <= 1'b0;
        pix_if.start_of_sprite <= 1'b0;
        pix_if.origin_x <= '0;
        pix_if.origin_y <= '0;
        pix_if.pixel <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= REG_SPRITE_WIDTH;
        cfg_if.data <= '0;
        blit_width = SIZE_W'(1);
        blit_height = SIZE_W'(1);
        blit_col = '0;
        blit_row = '0;
        blit_base_col = '0;
        blit_base_row = '0;
        blit_active = 1'b0;
        src_idle = 1'b0;
        snk_idle = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_sizes();
        test_clipping();
        test_restart();
        test_zero_size();
        test_resize_mid_sprite();
        test_random_sprites();

        wait_drained();
        repeat (8) @(posedge clk);
        $display("covered %0d pixel items over %0d size settings", n_pixels, n_settings);
        $display("results: %0d writes, %0d keyed or clipped, %0d sprites done, %0d mismatches",
                 n_fb_writes, n_no_writes, n_done, n_mismatch);
        if (n_mismatch == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
